FILE: design/assert_macros.svh
// Assertion macros shared by the deque RTL.
// No dependencies; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while in reset
`define DQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");
// next-cycle implication, sampled on clk, off while in reset
`define DQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define DQ_ASSERT_IMPL(lbl, ante, cons)
`define DQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: design/cdq_pkg.sv
// Shared constants and types for the circular deque.
// No dependencies.
package cdq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int FUNC_W    = 3;
  localparam int CAP_W     = 5;
  localparam int CAP_RST   = 16;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DEL_BACK  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_PEEK      = 3'd4;

  // per-word status carried from the control stage to the result stage
  typedef struct packed {
    logic ok;
    logic empty;
    logic full;
  } cdq_meta_t;

endpackage

FILE: design/cdq_in_if.sv
// Request channel of the circular deque: valid/ready plus operation word.
// Depends on cdq_pkg.
interface cdq_in_if;
  import cdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

FILE: design/cdq_out_if.sv
// Result channel of the circular deque: valid/ready plus status word.
// Depends on cdq_pkg.
interface cdq_out_if;
  import cdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] rear_value;
  logic                     is_empty;
  logic                     is_full;

  modport source (output valid, output ok, output front_value, output rear_value,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input ok, input front_value, input rear_value,
                  input is_empty, input is_full, output ready);
endinterface

FILE: design/cdq_mem.sv
// Slot store of the deque: one write port, two registered read ports.
// Depends on cdq_pkg; a read of the entry written in the same cycle
// returns the new word.
module cdq_mem #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [cdq_pkg::DATA_W-1:0]                   wr_data,
  input  logic                                         rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
  output logic [cdq_pkg::DATA_W-1:0]                   rd_data_a,
  output logic [cdq_pkg::DATA_W-1:0]                   rd_data_b
);
  import cdq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_a_r;
  logic [DATA_W-1:0] rd_b_r;

  // write the slot
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read both ports, forward a same-cycle write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : mem[rd_addr_a];
      rd_b_r <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;
endmodule

FILE: design/cdq_ctl.sv
// Pointer, occupancy and capacity control of the deque.
// Depends on cdq_pkg; drives the slot store write and read requests.
module cdq_ctl #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         accept,
  input  logic [cdq_pkg::FUNC_W-1:0]                   func,
  input  logic [cdq_pkg::DATA_W-1:0]                   value,
  input  logic                                         cfg_we,
  input  logic [cdq_pkg::CAP_W-1:0]                    cfg_wdata,
  output logic                                         wr_en,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  output logic [cdq_pkg::DATA_W-1:0]                   wr_data,
  output logic                                         rd_en,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_front,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_rear,
  output cdq_pkg::cdq_meta_t                           meta
);
  import cdq_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int CAP_RST_EFF = (CAP_RST > DEPTH) ? DEPTH : CAP_RST;

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [CNT_W-1:0] cap_r;
  logic [CW-1:0]    cap_in;
  logic [CW-1:0]    cap_clamp;
  logic [PTR_W-1:0] cap_last;
  logic [PTR_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
  logic             has_room, has_word, ok;

  // clamp a written capacity into 1..DEPTH
  always_comb begin
    cap_in = CW'(cfg_wdata);
    if (cap_in == '0) begin
      cap_clamp = CW'(1);
    end else if (cap_in > CW'(DEPTH)) begin
      cap_clamp = CW'(DEPTH);
    end else begin
      cap_clamp = cap_in;
    end
  end

  // ring wrap at the effective capacity
  assign cap_last = PTR_W'(cap_r - CNT_W'(1));
  assign head_inc = (head_r == cap_last) ? '0 : head_r + PTR_W'(1);
  assign head_dec = (head_r == '0) ? cap_last : head_r - PTR_W'(1);
  assign tail_inc = (tail_r == cap_last) ? '0 : tail_r + PTR_W'(1);
  assign tail_dec = (tail_r == '0) ? cap_last : tail_r - PTR_W'(1);
  assign has_room = (occ_r < cap_r);
  assign has_word = (occ_r != '0);

  // decode the operation
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    occ_nxt  = occ_r;
    ok       = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = head_r;
    unique case (func) inside
      FN_INS_FRONT: begin
        if (has_room) begin
          if (has_word) begin
            head_nxt = head_dec;
          end
          wr_en   = 1'b1;
          wr_addr = head_nxt;
          occ_nxt = occ_r + CNT_W'(1);
          ok      = 1'b1;
        end
      end
      FN_INS_BACK: begin
        if (has_room) begin
          if (has_word) begin
            tail_nxt = tail_inc;
          end
          wr_en   = 1'b1;
          wr_addr = tail_nxt;
          occ_nxt = occ_r + CNT_W'(1);
          ok      = 1'b1;
        end
      end
      FN_DEL_FRONT, FN_DEL_BACK: begin
        if (has_word) begin
          if (func == FN_DEL_FRONT) begin
            head_nxt = head_inc;
          end else begin
            tail_nxt = tail_dec;
          end
          occ_nxt = occ_r - CNT_W'(1);
          ok      = 1'b1;
          // rewind both pointers once the deque drains
          if (occ_nxt == '0) begin
            head_nxt = '0;
            tail_nxt = '0;
          end
        end
      end
      FN_PEEK: begin
        ok = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    wr_en = wr_en & accept;
  end

  assign wr_data       = value;
  assign rd_en         = accept;
  assign rd_addr_front = head_nxt;
  assign rd_addr_rear  = tail_nxt;
  assign meta.ok       = ok;
  assign meta.empty    = (occ_nxt == '0);
  assign meta.full     = (occ_nxt == cap_r);

  // advance pointers and count on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      occ_r  <= '0;
    end else if (accept) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      occ_r  <= occ_nxt;
    end
  end

  // take a new capacity only while the deque is empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CNT_W'(CAP_RST_EFF);
    end else if (cfg_we && (occ_r == '0)) begin
      cap_r <= CNT_W'(cap_clamp);
    end
  end
endmodule

FILE: design/circular_deque_unit.sv
// Circular deque: a double-ended queue of 32-bit words in a ring of slots.
// Depends on cdq_pkg, cdq_in_if, cdq_out_if, cdq_ctl, cdq_mem, assert_macros.svh.
`include "assert_macros.svh"

// One word is accepted every cycle while the read stage can take it. Each
// operation updates the head, tail and count in the cycle it is accepted and
// issues the write and both reads to the slot memory; the result passes
// through the registered read ports of the slot memory and then into the
// output register. Results stall without loss: the input takes a new word
// whenever the memory read stage can drain into the output register. Capacity
// (1..DEPTH, 0 reads as 1, larger values as DEPTH) is only taken while the
// deque is empty; otherwise the write is dropped.
module circular_deque_unit #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  cdq_in_if.sink                      in_ch,
  cdq_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [cdq_pkg::CAP_W-1:0]   cfg_wdata
);
  import cdq_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic              accept;
  logic              out_load;
  logic              wr_en, rd_en;
  logic [PTR_W-1:0]  wr_addr, rd_addr_front, rd_addr_rear;
  logic [DATA_W-1:0] wr_data, rd_front, rd_rear;
  cdq_meta_t         meta;

  logic              s1_vld_r, s1_vld_nxt;
  cdq_meta_t         s1_meta_r;
  logic              out_vld_r, out_vld_nxt;
  logic              out_ok_r, out_empty_r, out_full_r;
  logic [DATA_W-1:0] out_front_r, out_rear_r;

  // handshake: drain the read stage when the output register frees up
  assign out_load     = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !s1_vld_r || out_load;
  assign accept       = in_ch.valid && in_ch.ready;

  cdq_ctl #(.DEPTH(DEPTH)) u_ctl (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .func          (in_ch.func),
    .value         (in_ch.value),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_en         (rd_en),
    .rd_addr_front (rd_addr_front),
    .rd_addr_rear  (rd_addr_rear),
    .meta          (meta)
  );

  cdq_mem #(.DEPTH(DEPTH)) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_front),
    .rd_addr_b (rd_addr_rear),
    .rd_data_a (rd_front),
    .rd_data_b (rd_rear)
  );

  // stage valid bits
  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (accept) begin
      s1_vld_nxt = 1'b1;
    end else if (out_load) begin
      s1_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // hold status alongside the memory read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta_r <= meta;
    end
  end

  // load the result word, empty reads as all ones
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ok_r    <= s1_meta_r.ok;
      out_empty_r <= s1_meta_r.empty;
      out_full_r  <= s1_meta_r.full;
      out_front_r <= s1_meta_r.empty ? '1 : rd_front;
      out_rear_r  <= s1_meta_r.empty ? '1 : rd_rear;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.ok          = out_ok_r;
  assign out_ch.front_value = out_front_r;
  assign out_ch.rear_value  = out_rear_r;
  assign out_ch.is_empty    = out_empty_r;
  assign out_ch.is_full     = out_full_r;

  // a peek always reports success
  `DQ_ASSERT_NEXT(a_peek_ok, accept && (in_ch.func == FN_PEEK), s1_meta_r.ok)
  // a blocked read stage keeps its word
  `DQ_ASSERT_NEXT(a_s1_hold, s1_vld_r && !out_load, s1_vld_r && $stable(s1_meta_r))
  // capacity is at least one, so empty and full never coincide
  `DQ_ASSERT_IMPL(a_empty_full, out_vld_r, !(out_empty_r && out_full_r))
endmodule
